>>> design/fmrwq_pkg.sv
// fmrwq_pkg: shared types and constants for the fm register write queue
// no dependencies
`default_nettype none

package fmrwq_pkg;

  localparam int REG_W  = 8;
  localparam int DATA_W = 8;
  localparam int ENTRY_W = REG_W + DATA_W;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // register address bands
  localparam logic [REG_W-1:0] REG_OPERATOR_BASE = 8'h40;
  localparam logic [REG_W-1:0] REG_CHANNEL_BASE  = 8'h20;
  localparam logic [REG_W-1:0] REG_KEY_ON        = 8'h08;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FLUSH = 2'b10
  } state_t;

  typedef struct packed {
    logic [REG_W-1:0]  chip_register;
    logic [DATA_W-1:0] chip_data;
  } entry_t;

endpackage

`default_nettype wire

>>> design/fm_register_write_queue.sv
// fm_register_write_queue: fifo of fm chip register writes with address forming
// depends on fmrwq_pkg
// queue store is a single-port-read synchronous memory inside this module
`default_nettype none

// A write command forms the chip address and data byte and is stored, producing
// no result unless it fills the queue. A drain command on a non-empty queue reads
// one entry through mem_q and the output register and gives one result marked last;
// on an empty queue it is taken and gives nothing. A write that fills the queue starts
// a flush that emits all QUEUE_DEPTH entries oldest first, the final one marked last;
// its pace is set by the single memory read port and one read in flight ahead of
// the output register. Inputs are held off during the flush. The store needs no
// clearing after reset.
module fm_register_write_queue
  import fmrwq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_command,
  input  wire logic [2:0]        in_channel,
  input  wire logic [1:0]        in_operator_index,
  input  wire logic [REG_W-1:0]  in_register_base,
  input  wire logic [DATA_W-1:0] in_write_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [REG_W-1:0]       out_chip_register,
  output logic [DATA_W-1:0]      out_chip_data,
  output logic                   out_last_of_run
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  entry_t mem [QUEUE_DEPTH];
  entry_t mem_q;

  state_t            state_r, state_nxt;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              pending_r, pending_last_r;
  logic              out_valid_r;
  logic              out_last_r;
  entry_t            out_entry_r;

  logic              in_xfer, out_xfer;
  logic              wr_en, rd_en, rd_last;
  logic              out_free;
  entry_t            wr_entry;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall = (state_r != ST_IDLE) ||
                    ((in_command == CMD_DRAIN) && (count_r != '0) &&
                     (pending_r || out_valid_r));

  // address forming
  always_comb begin
    wr_entry.chip_register = in_register_base;
    wr_entry.chip_data     = in_write_data;
    if (in_register_base >= REG_OPERATOR_BASE) begin
      wr_entry.chip_register = in_register_base + {3'b000, in_operator_index, 3'b000}
                               + {5'b00000, in_channel};
    end else if (in_register_base >= REG_CHANNEL_BASE) begin
      wr_entry.chip_register = in_register_base + {5'b00000, in_channel};
    end else if (in_register_base == REG_KEY_ON) begin
      wr_entry.chip_data = in_write_data | {5'b00000, in_channel};
    end
  end

  always_comb begin
    state_nxt  = state_r;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_last    = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_command == CMD_WRITE) begin
            wr_en      = 1'b1;
            wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
            count_nxt  = count_r + 1'b1;
            if (count_nxt == CNT_FULL) begin
              state_nxt = ST_FLUSH;
            end
          end else if (count_r != '0) begin
            rd_en = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!pending_r && out_free) begin
          rd_en   = 1'b1;
          rd_last = (count_r == CNT_ONE);
          if (count_r == CNT_ONE) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      count_nxt  = count_r - 1'b1;
    end
  end

  // queue store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_entry;
    end
    if (rd_en) begin
      mem_q <= mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      wr_ptr_r  <= wr_ptr_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      count_r   <= count_nxt;
      pending_r <= rd_en;
      if (pending_r) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (rd_en) begin
      pending_last_r <= rd_last;
    end
    if (pending_r) begin
      out_entry_r <= mem_q;
      out_last_r  <= pending_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_chip_register = out_entry_r.chip_register;
  assign out_chip_data     = out_entry_r.chip_data;
  assign out_last_of_run   = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("entry count above queue depth");

  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> !out_valid_r)
    else $error("read data returned while output register occupied");

  a_flush_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) |-> in_stall)
    else $error("input transfer taken during flush");

  a_fill_starts_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_command == CMD_WRITE) && (count_r == CNT_FULL - CNT_ONE))
      |=> (state_r == ST_FLUSH))
    else $error("filling write did not start a flush");

  a_flush_ends_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FLUSH) && (state_nxt == ST_IDLE)) |=> (count_r == '0))
    else $error("flush ended with entries left");

endmodule

`default_nettype wire
